@@ rtl/bfi_pkg.sv @@
// shared types and constants for the bloom filter block
package bfi_pkg;

  localparam int DEF_MAX_TABLE_BYTES = 8192;
  localparam int DEF_MAX_HASH_COUNT  = 16;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;
  localparam int TABLE_BYTES_W = 14;
  localparam int HASH_COUNT_W  = 5;

  localparam logic [CFG_INDEX_W-1:0] REG_TABLE_BYTES = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HASH_COUNT  = 8'd1;

  localparam logic [TABLE_BYTES_W-1:0] TABLE_BYTES_RESET = 14'd8192;
  localparam logic [HASH_COUNT_W-1:0]  HASH_COUNT_RESET  = 5'd7;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [63:0] hash_value;
  } bfi_item_t;

endpackage

@@ rtl/bfi_front.sv @@
// front end: accepts items into a two-entry queue
module bfi_front import bfi_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      mode,
  input  logic [63:0] hash_value,
  output logic      q_valid,
  output bfi_item_t q_item,
  input  logic      q_pop
);

  bfi_item_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{mode: mode, hash_value: hash_value};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

@@ rtl/bfi_back.sv @@
// back end: probe sequencer, remainder unit and bit table
module bfi_back import bfi_pkg::*; #(
  parameter int MAX_TABLE_BYTES = DEF_MAX_TABLE_BYTES,
  parameter int MAX_HASH_COUNT  = DEF_MAX_HASH_COUNT,
  localparam int AW = (MAX_TABLE_BYTES > 1) ? $clog2(MAX_TABLE_BYTES) : 1,
  localparam int RW = $clog2(MAX_TABLE_BYTES * 8 + 1),
  localparam int PW = $clog2(MAX_HASH_COUNT + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [RW-1:0] nbits,
  input  logic [PW-1:0] probes,
  input  logic          q_valid,
  input  bfi_item_t     q_item,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          was_query,
  output logic          member
);

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_MOD, S_RD, S_CHK} state_t;

  state_t        state;
  logic [AW-1:0] clr_addr;
  logic          is_query;
  logic [31:0]   acc;
  logic [31:0]   step;
  logic [31:0]   dv;
  logic [RW-1:0] rem;
  logic [2:0]    cnt;
  logic [PW-1:0] k;
  logic [AW-1:0] addr;
  logic [2:0]    sel;
  logic [7:0]    rdata;
  logic [7:0]    mem [MAX_TABLE_BYTES];

  logic [RW-1:0] mod_r;
  logic [RW-1:0] rd_shift;
  logic [AW-1:0] rd_addr;
  logic [31:0]   acc_next;
  logic [PW-1:0] k_next;
  logic          hit;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;

  // four restoring remainder steps per cycle
  always_comb begin
    logic [RW:0]  t;
    logic [31:0]  d;
    mod_r = rem;
    d = dv;
    for (int i = 0; i < 4; i++) begin
      t = {mod_r, d[31]};
      d = d << 1;
      if (t >= {1'b0, nbits}) t = t - {1'b0, nbits};
      mod_r = t[RW-1:0];
    end
  end

  assign rd_shift = rem >> 3;
  assign rd_addr  = rd_shift[AW-1:0];
  assign acc_next = acc + step;
  assign k_next   = k + PW'(1);
  assign hit      = rdata[sel];
  assign q_pop    = (state == S_IDLE) && q_valid && !out_valid;

  assign mem_we    = (state == S_CLR) || ((state == S_CHK) && !is_query);
  assign mem_waddr = (state == S_CLR) ? clr_addr : addr;
  assign mem_wdata = (state == S_CLR) ? 8'h00 : (rdata | (8'h01 << sel));

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (state == S_RD) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(MAX_TABLE_BYTES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_pop) begin
            is_query <= (q_item.mode == MODE_QUERY);
            acc      <= q_item.hash_value[63:32];
            dv       <= q_item.hash_value[63:32];
            step     <= q_item.hash_value[31:0];
            rem      <= '0;
            cnt      <= 3'd0;
            k        <= '0;
            if (probes == '0) begin
              out_valid <= 1'b1;
              was_query <= (q_item.mode == MODE_QUERY);
              member    <= (q_item.mode == MODE_QUERY);
            end else begin
              state <= S_MOD;
            end
          end
        end
        S_MOD: begin
          rem <= mod_r;
          dv  <= dv << 4;
          cnt <= cnt + 3'd1;
          if (cnt == 3'd7) state <= S_RD;
        end
        S_RD: begin
          addr  <= rd_addr;
          sel   <= rem[2:0];
          state <= S_CHK;
        end
        S_CHK: begin
          if ((is_query && !hit) || (k_next == probes)) begin
            out_valid <= 1'b1;
            was_query <= is_query;
            member    <= is_query && hit;
            state     <= S_IDLE;
          end else begin
            k     <= k_next;
            acc   <= acc_next;
            dv    <= acc_next;
            rem   <= '0;
            cnt   <= 3'd0;
            state <= S_MOD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_member_query: assert property (@(posedge clk) disable iff (rst)
    out_valid && member |-> was_query) else $error("member set on insert result");
  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLR |-> !q_pop) else $error("item taken during table clear");
  a_chk_after_rd: assert property (@(posedge clk) disable iff (rst)
    state == S_CHK |-> $past(state == S_RD)) else $error("check without read");
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_RD |-> rem < nbits) else $error("probe position out of range");

endmodule

@@ rtl/bloom_filter_insert_and_query.sv @@
// each probe runs the remainder steps in S_MOD, then a table read (S_RD) and a check (S_CHK)
// a query stops at the first clear bit; zero probes give a result straight from S_IDLE
// one item in the probe sequencer at a time; the next is taken in S_IDLE once the last result is accepted
// reset clears all MAX_TABLE_BYTES bytes of the bit table; two beats queue meanwhile
// configuration registers reset to 8192 table bytes and 7 probes
// top level: configuration registers, clamping, front and back
module bloom_filter_insert_and_query import bfi_pkg::*; #(
  parameter int MAX_TABLE_BYTES = DEF_MAX_TABLE_BYTES,
  parameter int MAX_HASH_COUNT  = DEF_MAX_HASH_COUNT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   mode,
  input  logic [63:0]            hash_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   was_query,
  output logic                   member
);

  localparam int RW = $clog2(MAX_TABLE_BYTES * 8 + 1);
  localparam int PW = $clog2(MAX_HASH_COUNT + 1);

  logic [TABLE_BYTES_W-1:0] table_bytes;
  logic [HASH_COUNT_W-1:0]  hash_count;
  logic [31:0]              bytes_used;
  logic [31:0]              bits_used;
  logic [RW-1:0]            nbits;
  logic [PW-1:0]            probes;
  logic                     q_valid;
  logic                     q_pop;
  bfi_item_t                q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_bytes <= TABLE_BYTES_RESET;
      hash_count  <= HASH_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_TABLE_BYTES) table_bytes <= cfg_data[TABLE_BYTES_W-1:0];
      if (cfg_index == REG_HASH_COUNT)  hash_count  <= cfg_data[HASH_COUNT_W-1:0];
    end
  end

  always_comb begin
    priority if (table_bytes == '0) bytes_used = 32'd1;
    else if (32'(table_bytes) > 32'(MAX_TABLE_BYTES)) bytes_used = 32'(MAX_TABLE_BYTES);
    else bytes_used = 32'(table_bytes);
    bits_used = bytes_used << 3;
    nbits = bits_used[RW-1:0];
    if (32'(hash_count) > 32'(MAX_HASH_COUNT)) probes = PW'(MAX_HASH_COUNT);
    else probes = PW'(hash_count);
  end

  bfi_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .hash_value (hash_value),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  bfi_back #(
    .MAX_TABLE_BYTES (MAX_TABLE_BYTES),
    .MAX_HASH_COUNT  (MAX_HASH_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .nbits     (nbits),
    .probes    (probes),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .was_query (was_query),
    .member    (member)
  );

endmodule
